### rtl/core/fxa_pkg.sv
// shared types and constants of the q24.8 fixed-point alu
package fxa_pkg;

    localparam int W  = 32;
    localparam int PW = 64;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } t_op;

    typedef enum logic [1:0] {
        K_SIMPLE = 2'd0,
        K_MUL    = 2'd1,
        K_DIV    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic                  neg;
        logic signed [PW-1:0]  prod;
        logic [W-1:0]          val;
        logic                  cmp;
        logic                  ovf;
        logic                  dz;
    } t_side;

    localparam logic [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};

endpackage

### rtl/core/fxa_if.sv
// transfer channels of the alu
interface fxa_in_if;
    logic                 valid;
    logic                 ready;
    logic [3:0]           op;
    logic signed [31:0]   operand_a;
    logic signed [31:0]   operand_b;
    modport source (output valid, op, operand_a, operand_b, input ready);
    modport sink   (input valid, op, operand_a, operand_b, output ready);
endinterface

interface fxa_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   value_out;
    logic                 compare_true;
    logic                 overflow;
    logic                 divide_by_zero;
    modport source (output valid, value_out, compare_true, overflow, divide_by_zero,
                    input ready);
    modport sink   (input valid, value_out, compare_true, overflow, divide_by_zero,
                    output ready);
endinterface

### rtl/core/fxa_front.sv
// first stage: simple operations, multiplier and divider setup
module fxa_front #(
    parameter int FRAC_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [3:0]                   i_op,
    input  logic signed [31:0]           i_a,
    input  logic signed [31:0]           i_b,
    output logic                         o_valid,
    output fxa_pkg::t_side               o_side,
    output logic [32+FRAC_BITS-1:0]      o_num,
    output logic [31:0]                  o_den
);
    import fxa_pkg::*;

    localparam int NW = W + FRAC_BITS;

    logic                  r_valid;
    t_side                 r_side, n_side;
    logic [NW-1:0]         r_num;
    logic [W-1:0]          r_den;
    logic signed [W:0]     sum, dif;
    logic [W-1:0]          mag_a, mag_b;
    logic [FRAC_BITS:0]    hi;
    logic                  lt, eq;

    always_comb begin
        sum   = {i_a[W-1], i_a} + {i_b[W-1], i_b};
        dif   = {i_a[W-1], i_a} - {i_b[W-1], i_b};
        mag_a = i_a[W-1] ? W'(-i_a) : W'(i_a);
        mag_b = i_b[W-1] ? W'(-i_b) : W'(i_b);
        hi    = i_a[W-1 -: FRAC_BITS+1];
        lt    = i_a < i_b;
        eq    = i_a == i_b;
        n_side      = '0;
        n_side.kind = K_SIMPLE;
        n_side.prod = PW'(i_a * i_b);
        n_side.neg  = i_a[W-1] ^ i_b[W-1];
        case (t_op'(i_op))
            OP_ADD: begin
                n_side.ovf = sum[W] ^ sum[W-1];
                n_side.val = n_side.ovf ? (sum[W] ? S_MIN : S_MAX) : sum[W-1:0];
            end
            OP_SUB: begin
                n_side.ovf = dif[W] ^ dif[W-1];
                n_side.val = n_side.ovf ? (dif[W] ? S_MIN : S_MAX) : dif[W-1:0];
            end
            OP_MUL: n_side.kind = K_MUL;
            OP_DIV: begin
                if (i_b == '0) begin
                    n_side.dz = 1'b1;
                end else begin
                    n_side.kind = K_DIV;
                end
            end
            OP_GT: n_side.cmp = !lt && !eq;
            OP_LT: n_side.cmp = lt;
            OP_GE: n_side.cmp = !lt;
            OP_LE: n_side.cmp = lt || eq;
            OP_EQ: n_side.cmp = eq;
            OP_NE: n_side.cmp = !eq;
            OP_MIN: n_side.val = lt ? i_a : i_b;
            OP_MAX: n_side.val = (!lt && !eq) ? i_a : i_b;
            OP_INC: begin
                n_side.ovf = (i_a == S_MAX);
                n_side.val = n_side.ovf ? S_MAX : W'(i_a + 32'sd1);
            end
            OP_DEC: begin
                n_side.ovf = (i_a == S_MIN);
                n_side.val = n_side.ovf ? S_MIN : W'(i_a - 32'sd1);
            end
            OP_FROM_INT: begin
                n_side.ovf = !((&hi) || !(|hi));
                n_side.val = n_side.ovf ? (i_a[W-1] ? S_MIN : S_MAX)
                                        : W'(i_a <<< FRAC_BITS);
            end
            OP_TO_INT: n_side.val = W'(i_a >>> FRAC_BITS);
            default: n_side.val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_side <= n_side;
            r_num  <= {mag_a, {FRAC_BITS{1'b0}}};
            r_den  <= mag_b;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_num   = r_num;
    assign o_den   = r_den;

endmodule

### rtl/core/fxa_div_stage.sv
// one quotient bit of the pipelined restoring divider
module fxa_div_stage #(
    parameter int NW = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  fxa_pkg::t_side       i_side,
    input  logic [31:0]          i_rem,
    input  logic [NW-1:0]        i_quo,
    input  logic [NW-1:0]        i_num,
    input  logic [31:0]          i_den,
    output logic                 o_valid,
    output fxa_pkg::t_side       o_side,
    output logic [31:0]          o_rem,
    output logic [NW-1:0]        o_quo,
    output logic [NW-1:0]        o_num,
    output logic [31:0]          o_den
);
    import fxa_pkg::*;

    logic            r_valid;
    t_side           r_side;
    logic [W-1:0]    r_rem, r_den;
    logic [NW-1:0]   r_quo, r_num;
    logic [W:0]      part, diff;
    logic            ge;

    always_comb begin
        part = {i_rem, i_num[NW-1]};
        diff = part - {1'b0, i_den};
        ge   = part >= {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_side <= i_side;
            r_rem  <= ge ? diff[W-1:0] : part[W-1:0];
            r_quo  <= {i_quo[NW-2:0], ge};
            r_num  <= {i_num[NW-2:0], 1'b0};
            r_den  <= i_den;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_num   = r_num;
    assign o_den   = r_den;

endmodule

### rtl/core/fxa_back.sv
// last stage: rounding, saturation and result register
module fxa_back #(
    parameter int FRAC_BITS = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  fxa_pkg::t_side            i_side,
    input  logic [31:0]               i_rem,
    input  logic [32+FRAC_BITS-1:0]   i_quo,
    input  logic [31:0]               i_den,
    output logic                      o_valid,
    output logic [31:0]               o_val,
    output logic                      o_cmp,
    output logic                      o_ovf,
    output logic                      o_dz
);
    import fxa_pkg::*;

    localparam int NW = W + FRAC_BITS;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    logic            r_valid, r_cmp, r_ovf, r_dz;
    logic [W-1:0]    r_val;
    logic [PW-1:0]   pmag, mag, limit;
    logic [NW:0]     qr;
    logic            up, neg;
    logic [W-1:0]    n_val;
    logic            n_ovf;

    always_comb begin
        pmag  = i_side.prod[PW-1] ? PW'(-i_side.prod) : PW'(i_side.prod);
        up    = {i_rem, 1'b0} >= {1'b0, i_den};
        qr    = {1'b0, i_quo} + (NW+1)'(up);
        if (i_side.kind == K_MUL) begin
            mag = (pmag + HALF) >> FRAC_BITS;
            neg = i_side.prod[PW-1];
        end else begin
            mag = PW'(qr);
            neg = i_side.neg;
        end
        limit = neg ? PW'(S_MIN) : PW'(S_MAX);
        n_val = i_side.val;
        n_ovf = i_side.ovf;
        if (i_side.kind != K_SIMPLE) begin
            if (mag > limit) begin
                n_ovf = 1'b1;
                n_val = neg ? S_MIN : S_MAX;
            end else begin
                n_ovf = 1'b0;
                n_val = neg ? W'(-mag[W-1:0]) : mag[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_val <= n_val;
            r_ovf <= n_ovf;
            r_cmp <= i_side.cmp;
            r_dz  <= i_side.dz;
        end
    end

    assign o_valid = r_valid;
    assign o_val   = r_val;
    assign o_cmp   = r_cmp;
    assign o_ovf   = r_ovf;
    assign o_dz    = r_dz;

endmodule

### rtl/core/fixed_point_q24_8_alu.sv
// top level of the q24.8 fixed-point alu
// pipeline: one setup stage, one divider stage per numerator bit, one rounding stage;
// throughput one transfer per cycle while the output transfer is not stalled
// the whole pipeline advances together and holds while the output transfer is stalled
// synchronous active-low reset clears every stage valid bit; no other state
module fixed_point_q24_8_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fxa_in_if.sink       i_in,
    fxa_out_if.source    o_out
);
    import fxa_pkg::*;

    localparam int NW = W + FRAC_BITS;

    logic            en;
    logic            v   [0:NW];
    t_side           sd  [0:NW];
    logic [W-1:0]    rem [0:NW];
    logic [NW-1:0]   quo [0:NW];
    logic [NW-1:0]   num [0:NW];
    logic [W-1:0]    den [0:NW];
    logic [W-1:0]    val;

    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;
    assign rem[0]     = '0;
    assign quo[0]     = '0;

    fxa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_op    (i_in.op),
        .i_a     (i_in.operand_a),
        .i_b     (i_in.operand_b),
        .o_valid (v[0]),
        .o_side  (sd[0]),
        .o_num   (num[0]),
        .o_den   (den[0])
    );

    for (genvar g = 0; g < NW; g++) begin : g_div
        fxa_div_stage #(.NW(NW)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[g]),
            .i_side  (sd[g]),
            .i_rem   (rem[g]),
            .i_quo   (quo[g]),
            .i_num   (num[g]),
            .i_den   (den[g]),
            .o_valid (v[g+1]),
            .o_side  (sd[g+1]),
            .o_rem   (rem[g+1]),
            .o_quo   (quo[g+1]),
            .o_num   (num[g+1]),
            .o_den   (den[g+1])
        );
    end

    fxa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v[NW]),
        .i_side  (sd[NW]),
        .i_rem   (rem[NW]),
        .i_quo   (quo[NW]),
        .i_den   (den[NW]),
        .o_valid (o_out.valid),
        .o_val   (val),
        .o_cmp   (o_out.compare_true),
        .o_ovf   (o_out.overflow),
        .o_dz    (o_out.divide_by_zero)
    );

    assign o_out.value_out = val;

endmodule

### dv/fixed_point_q24_8_alu_tb.sv
// self-checking testbench of the q24.8 fixed-point alu: directed table then random transfers
module fixed_point_q24_8_alu_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fxa_pkg::*;

    localparam int FRAC    = 8;
    localparam int N_RAND  = 1200;
    localparam int LATENCY = FRAC + 34;
    localparam int LIMIT   = 400000;

    typedef struct {
        logic signed [31:0] value;
        logic               cmp;
        logic               ovf;
        logic               dz;
    } t_res;

    typedef struct {
        t_op                op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               known;
        t_res               res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycles = 0;
    int   errors = 0;
    t_res alu_results[$];

    fxa_in_if  in_ch();
    fxa_out_if out_ch();

    fixed_point_q24_8_alu #(.FRAC_BITS(FRAC)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [31:0] clamp(input logic signed [63:0] v,
                                                 inout logic ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_res alu_predict(input t_op op, input logic signed [31:0] a,
                                         input logic signed [31:0] b);
        t_res r;
        logic signed [63:0] sa, sb, p;
        logic [63:0] m, num, den;
        logic neg;
        r = '{0, 0, 0, 0};
        sa = a;
        sb = b;
        case (op)
            OP_ADD: r.value = clamp(sa + sb, r.ovf);
            OP_SUB: r.value = clamp(sa - sb, r.ovf);
            OP_MUL: begin
                p = sa * sb;
                neg = p < 0;
                m = neg ? -p : p;
                m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
                r.value = clamp(neg ? -$signed(m) : $signed(m), r.ovf);
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    neg = (sa < 0) != (sb < 0);
                    num = (sa < 0 ? -sa : sa) << FRAC;
                    den = sb < 0 ? -sb : sb;
                    m = (2 * num + den) / (2 * den);
                    r.value = clamp(neg ? -$signed(m) : $signed(m), r.ovf);
                end
            end
            OP_GT: r.cmp = a > b;
            OP_LT: r.cmp = a < b;
            OP_GE: r.cmp = a >= b;
            OP_LE: r.cmp = a <= b;
            OP_EQ: r.cmp = a == b;
            OP_NE: r.cmp = a != b;
            OP_MIN: r.value = a < b ? a : b;
            OP_MAX: r.value = a > b ? a : b;
            OP_INC: r.value = clamp(sa + 1, r.ovf);
            OP_DEC: r.value = clamp(sa - 1, r.ovf);
            OP_FROM_INT: r.value = clamp(sa * (64'sd1 <<< FRAC), r.ovf);
            default: r.value = a >>> FRAC;
        endcase
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    localparam logic signed [31:0] MX = 32'sh7fffffff;
    localparam logic signed [31:0] MN = 32'sh80000000;
    localparam int N_DIR = 22;
    t_row dir_rows[N_DIR] = '{
        '{OP_ADD, MX, 1, 1, '{MX, 0, 1, 0}},
        '{OP_ADD, MN, -1, 1, '{MN, 0, 1, 0}},
        '{OP_SUB, MN, 1, 1, '{MN, 0, 1, 0}},
        '{OP_SUB, MX, -1, 1, '{MX, 0, 1, 0}},
        '{OP_MUL, MX, MX, 1, '{MX, 0, 1, 0}},
        '{OP_MUL, MN, MX, 1, '{MN, 0, 1, 0}},
        '{OP_MUL, -384, 128, 0, '{0, 0, 0, 0}},
        '{OP_DIV, 256, 0, 1, '{0, 0, 0, 1}},
        '{OP_DIV, MN, 0, 1, '{0, 0, 0, 1}},
        '{OP_DIV, MX, 1, 1, '{MX, 0, 1, 0}},
        '{OP_DIV, -256, 512, 0, '{0, 0, 0, 0}},
        '{OP_GT, MX, MN, 1, '{0, 1, 0, 0}},
        '{OP_LT, MX, MN, 1, '{0, 0, 0, 0}},
        '{OP_GE, 5, 5, 1, '{0, 1, 0, 0}},
        '{OP_LE, MN, MX, 1, '{0, 1, 0, 0}},
        '{OP_EQ, MN, MN, 1, '{0, 1, 0, 0}},
        '{OP_NE, MN, MN, 1, '{0, 0, 0, 0}},
        '{OP_MIN, MN, MX, 1, '{MN, 0, 0, 0}},
        '{OP_MAX, MN, MX, 1, '{MX, 0, 0, 0}},
        '{OP_INC, MX, 0, 1, '{MX, 0, 1, 0}},
        '{OP_DEC, MN, 0, 1, '{MN, 0, 1, 0}},
        '{OP_FROM_INT, MN, 0, 1, '{MN, 0, 1, 0}}
    };

    task automatic send(input t_op op, input logic signed [31:0] a, input logic signed [31:0] b);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.operand_a <= a;
        in_ch.operand_b <= b;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return MX - $urandom_range(0, 3);
            1: return MN + $urandom_range(0, 3);
            2: return $signed($urandom_range(0, 2047)) - 1024;
            3: return $signed($urandom) >>> $urandom_range(8, 24);
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_res w;
        if (i_rst_n && in_ch.valid && in_ch.ready)
            alu_results.push_back(alu_predict(t_op'(in_ch.op), in_ch.operand_a,
                                              in_ch.operand_b));
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (alu_results.size() == 0) begin
                report("unexpected transfer", out_ch.value_out, 0);
            end else begin
                w = alu_results.pop_front();
                if (out_ch.value_out !== w.value) report("value", out_ch.value_out, w.value);
                if (out_ch.compare_true !== w.cmp) report("compare", out_ch.compare_true, w.cmp);
                if (out_ch.overflow !== w.ovf) report("overflow", out_ch.overflow, w.ovf);
                if (out_ch.divide_by_zero !== w.dz) report("div zero", out_ch.divide_by_zero, w.dz);
            end
        end
    end

    initial begin
        int stall;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready || !out_ch.ready) begin
                stall = $urandom_range(0, 7);
                if ($urandom_range(0, 3) == 0) stall = 0;
                if (stall != 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        t_res r;
        in_ch.valid = 1'b0;
        in_ch.op = '0;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < N_DIR; i++) begin
            if (dir_rows[i].known) begin
                r = alu_predict(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b);
                if (r.value !== dir_rows[i].res.value || r.cmp !== dir_rows[i].res.cmp ||
                    r.ovf !== dir_rows[i].res.ovf || r.dz !== dir_rows[i].res.dz)
                    report("table row", i, 0);
            end
            send(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b);
        end
        send(OP_TO_INT, MN, 0);
        send(OP_TO_INT, -1, 0);
        for (int i = 0; i < N_RAND; i++)
            send(t_op'($urandom_range(0, 15)), rand_operand(), $urandom_range(0, 7) == 0 ? 0 :
                 rand_operand());
        in_ch.valid <= 1'b0;
        while (alu_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY * 2) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
